/* design/murmur_style_hash64_stream_macros.svh */
// ----------------------------------------------------------------------------
// murmur_style_hash64_stream_macros
// assertion macros shared by the hash block modules
// ----------------------------------------------------------------------------
`ifndef MURMUR_STYLE_HASH64_STREAM_MACROS_SVH
`define MURMUR_STYLE_HASH64_STREAM_MACROS_SVH

// same-cycle implication
`define MSH_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSH_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define MSH_ASSERT_DLY(label, ck, rs, ante, n, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

/* design/mshash_pkg.sv */
// ----------------------------------------------------------------------------
// mshash_pkg
// types, constants and the constant multiplier shared by the hash block
// ----------------------------------------------------------------------------
package mshash_pkg;

  // half of the 64-bit multiplier; both halves are equal
  localparam logic [31:0] MUL_HALF = 32'h5bd1e995;

  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  localparam logic [2:0] FULL_BYTES = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_HM,
    S_FIN
  } state_t;

  // value fed to the first multiply of a mixing round
  typedef enum logic [1:0] {
    SRC_WORD,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    OP_SRC,
    OP_KMIX,
    OP_ACC,
    OP_FIN
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
    src_t src;
    logic k_we;
    logic acc_we;
    logic fin_we;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic full;
    logic out_free;
  } status_t;

  // x * 0x5bd1e9955bd1e995 modulo 2^64, built from 32-bit products
  function automatic logic [63:0] mul_m(input logic [63:0] x);
    logic [63:0] p_lo;
    logic [63:0] p_cross;
    logic [31:0] s;
    s       = x[31:0] + x[63:32];
    p_lo    = {32'b0, x[31:0]} * {32'b0, MUL_HALF};
    p_cross = {32'b0, s} * {32'b0, MUL_HALF};
    return p_lo + {p_cross[31:0], 32'b0};
  endfunction

endpackage

/* design/murmur_style_hash64_stream.sv */
// A plain word is accepted, then takes three passes of the multiplier. A last
// item with 4 bytes adds a zero-tail round and a length round, then the final
// step; with 0 to 3 bytes a length round and the final step follow. No new word
// is taken until its rounds end; the one 64-bit multiplier is used once per cycle.
// Reset (synchronous, rst high): seed, accumulator and length cleared, output empty.
// ----------------------------------------------------------------------------
// murmur_style_hash64_stream
// streaming 64-bit multiplicative hash over 32-bit little-endian words
// ----------------------------------------------------------------------------
module murmur_style_hash64_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash_value
);

  mshash_pkg::cmd_t    cmd;
  mshash_pkg::status_t sts;

  // round sequencer
  mshash_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hash datapath
  mshash_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .cmd        (cmd),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .hash_value (hash_value),
    .sts        (sts)
  );

endmodule

/* design/mshash_ctrl.sv */
// ----------------------------------------------------------------------------
// mshash_ctrl
// sequencer for the mixing rounds and the final step of the hash
// ----------------------------------------------------------------------------
`include "murmur_style_hash64_stream_macros.svh"

module mshash_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mshash_pkg::status_t sts,
  output mshash_pkg::cmd_t    cmd
);

  mshash_pkg::state_t state, state_next;
  mshash_pkg::src_t   src, src_next;

  // state and round source registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mshash_pkg::S_IDLE;
      src   <= mshash_pkg::SRC_WORD;
    end else begin
      state <= state_next;
      src   <= src_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    src_next   = src;
    in_stall   = 1'b1;
    cmd        = '{load: 1'b0, op: mshash_pkg::OP_SRC, src: src,
                   k_we: 1'b0, acc_we: 1'b0, fin_we: 1'b0};
    case (state)
      mshash_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          src_next   = mshash_pkg::SRC_WORD;
          state_next = mshash_pkg::S_K1;
        end
      end
      mshash_pkg::S_K1: begin
        cmd.op     = mshash_pkg::OP_SRC;
        cmd.k_we   = 1'b1;
        state_next = mshash_pkg::S_K2;
      end
      mshash_pkg::S_K2: begin
        cmd.op     = mshash_pkg::OP_KMIX;
        cmd.k_we   = 1'b1;
        state_next = mshash_pkg::S_HM;
      end
      mshash_pkg::S_HM: begin
        cmd.op     = mshash_pkg::OP_ACC;
        cmd.acc_we = 1'b1;
        if (!sts.last) begin
          state_next = mshash_pkg::S_IDLE;
        end else begin
          // last word: zero-tail round if the word was full, length round, then finish
          case (src)
            mshash_pkg::SRC_WORD: begin
              src_next   = sts.full ? mshash_pkg::SRC_ZERO : mshash_pkg::SRC_LEN;
              state_next = mshash_pkg::S_K1;
            end
            mshash_pkg::SRC_ZERO: begin
              src_next   = mshash_pkg::SRC_LEN;
              state_next = mshash_pkg::S_K1;
            end
            default: begin
              state_next = mshash_pkg::S_FIN;
            end
          endcase
        end
      end
      mshash_pkg::S_FIN: begin
        cmd.op = mshash_pkg::OP_FIN;
        if (sts.out_free) begin
          cmd.fin_we = 1'b1;
          state_next = mshash_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mshash_pkg::S_IDLE;
      end
    endcase
  end

  // after accept, the first round passes through S_K1 and S_K2 to the accumulator multiply
  `MSH_ASSERT_DLY(a_word_cycles, clk, rst, cmd.load, 3, state == mshash_pkg::S_HM, "word round length wrong")
  `MSH_ASSERT_NXT(a_load_starts, clk, rst, cmd.load, state == mshash_pkg::S_K1 && src == mshash_pkg::SRC_WORD, "round did not start on word")
  `MSH_ASSERT_IMP(a_fin_free, clk, rst, cmd.fin_we, sts.out_free && state == mshash_pkg::S_FIN, "result written while output busy")

endmodule

/* design/mshash_dp.sv */
// ----------------------------------------------------------------------------
// mshash_dp
// accumulator, length counter, shared constant multiplier and output register
// ----------------------------------------------------------------------------
`include "murmur_style_hash64_stream_macros.svh"

module mshash_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [63:0]         cfg_wdata,
  input  logic [31:0]         data_word,
  input  logic [2:0]          byte_count,
  input  logic                last,
  input  mshash_pkg::cmd_t    cmd,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [63:0]         hash_value,
  output mshash_pkg::status_t sts
);

  logic [63:0] seed;
  logic [63:0] acc;
  logic [63:0] len;
  logic [31:0] kin;
  logic [63:0] k;
  logic        last_r;
  logic        full_r;

  logic [2:0]  cnt_sat;
  logic [31:0] kin_next;
  logic [2:0]  len_add;
  logic        full_next;
  logic [63:0] operand;
  logic [63:0] prod;
  logic        out_free;

  // byte count of the incoming word, saturated, and the masked tail
  always_comb begin
    cnt_sat = (byte_count > mshash_pkg::FULL_BYTES) ? mshash_pkg::FULL_BYTES : byte_count;
    case (cnt_sat)
      3'd0:    kin_next = 32'b0;
      3'd1:    kin_next = {24'b0, data_word[7:0]};
      3'd2:    kin_next = {16'b0, data_word[15:0]};
      3'd3:    kin_next = {8'b0, data_word[23:0]};
      default: kin_next = data_word;
    endcase
    if (!last) begin
      kin_next = data_word;
    end
    full_next = !last || (cnt_sat == mshash_pkg::FULL_BYTES);
    len_add   = last ? cnt_sat : mshash_pkg::FULL_BYTES;
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.op)
      mshash_pkg::OP_SRC: begin
        case (cmd.src)
          mshash_pkg::SRC_WORD: operand = {32'b0, kin};
          mshash_pkg::SRC_LEN:  operand = len;
          default:              operand = 64'b0;
        endcase
      end
      mshash_pkg::OP_KMIX: operand = k ^ (k >> mshash_pkg::MIX_SHIFT);
      mshash_pkg::OP_ACC:  operand = acc;
      default:             operand = acc ^ (acc >> mshash_pkg::FIN_SHIFT_A);
    endcase
    prod = mshash_pkg::mul_m(operand);
  end

  assign out_free     = !out_valid || !out_stall;
  assign sts.last     = last_r;
  assign sts.full     = full_r;
  assign sts.out_free = out_free;

  // control state: seed, accumulator, length count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= 64'b0;
      acc       <= 64'b0;
      len       <= 64'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        len <= len + {61'b0, len_add};
      end
      if (cmd.acc_we) begin
        acc <= prod ^ k;
      end
      if (cmd.fin_we) begin
        acc       <= seed;
        len       <= 64'b0;
        out_valid <= 1'b1;
      end
      // seed write reloads the accumulator between messages
      if (cfg_we) begin
        seed <= cfg_wdata;
        if (len == 64'b0) begin
          acc <= cfg_wdata;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kin    <= kin_next;
      last_r <= last;
      full_r <= full_next;
    end
    if (cmd.k_we) begin
      k <= prod;
    end
    if (cmd.fin_we) begin
      hash_value <= prod ^ (prod >> mshash_pkg::FIN_SHIFT_B);
    end
  end

  `MSH_ASSERT_NXT(a_fin_clears_len, clk, rst, cmd.fin_we, len == 64'b0, "length not cleared after result")
  `MSH_ASSERT_IMP(a_out_from_fin, clk, rst, $rose(out_valid), $past(cmd.fin_we), "output valid without a result")

endmodule

/* verif/murmur_style_hash64_stream_test.sv */
// ----------------------------------------------------------------------------
// murmur_style_hash64_stream_test
// self-checking bench for the streaming 64-bit multiplicative hash: a table of
// directed words, then random messages under several seeds with random idling
// on both sides but in one brisk phase, every hash compared against an in-bench
// model of the mixing or a known hash from the table
module murmur_style_hash64_stream_test;

  localparam logic [63:0] HASH_MUL   = 64'h5bd1_e995_5bd1_e995;
  localparam int unsigned MIX_SH     = 24;
  localparam int unsigned FIN_SH_A   = 13;
  localparam int unsigned FIN_SH_B   = 15;
  localparam logic [2:0]  FULL_WORD  = 3'd4;
  localparam int unsigned PHASE_WORDS = 100;
  localparam int unsigned LONG_HOLD  = 600;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        fin;
    logic        known;
    logic [63:0] hash;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [63:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] hash_value;

  // model state
  logic [63:0] seed_model;
  logic [63:0] acc_model;
  logic [63:0] len_model;

  logic [63:0] pending_hashes[$];
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned msgs_sent;
  int unsigned hashes_checked;
  int unsigned seeds_written;
  bit          brisk;
  bit          long_hold_req;

  // empty message under a zero seed mixes only zeros, so its hash is zero
  stim_row_t dir_rows [18] = '{
    '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 64'h0},
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 64'h0},
    '{32'h0000_00AB, 3'd1, 1'b1, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, 3'd1, 1'b1, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, 3'd2, 1'b1, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, 3'd3, 1'b1, 1'b0, 64'h0},
    '{32'h8000_0001, 3'd4, 1'b1, 1'b0, 64'h0},
    '{32'h0000_0000, 3'd4, 1'b1, 1'b0, 64'h0},
    '{32'hDEAD_BEEF, 3'd5, 1'b1, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, 64'h0},
    '{32'h0123_4567, 3'd4, 1'b0, 1'b0, 64'h0},
    '{32'h89AB_CDEF, 3'd4, 1'b0, 1'b0, 64'h0},
    '{32'h0000_0000, 3'd3, 1'b1, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 64'h0},
    '{32'hFFFF_FFFF, 3'd6, 1'b0, 1'b0, 64'h0},
    '{32'hFEDC_BA98, 3'd2, 1'b1, 1'b0, 64'h0},
    '{32'h0000_0000, 3'd7, 1'b0, 1'b0, 64'h0},
    '{32'h5555_5555, 3'd4, 1'b1, 1'b0, 64'h0}
  };

  murmur_style_hash64_stream u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // one mixing round: scramble k, fold it into h
  function automatic logic [63:0] mix_round(input logic [63:0] h, input logic [63:0] k);
    logic [63:0] m;
    m = k * HASH_MUL;
    m = m ^ (m >> MIX_SH);
    m = m * HASH_MUL;
    return (h * HASH_MUL) ^ m;
  endfunction

  // advance the model by one accepted word; done is set when a hash falls out
  task automatic hash_step(input logic [31:0] w, input logic [2:0] n, input logic fin,
                           output logic done, output logic [63:0] digest);
    logic [63:0] h;
    logic [63:0] tail;
    logic [2:0]  take;
    done   = fin;
    digest = '0;
    if (!fin) begin
      // count is ignored on inner words
      acc_model = mix_round(acc_model, {32'b0, w});
      len_model = len_model + 64'd4;
    end else begin
      take = (n > FULL_WORD) ? FULL_WORD : n;
      h    = acc_model;
      if (take == FULL_WORD) begin
        h         = mix_round(h, {32'b0, w});
        len_model = len_model + 64'd4;
        tail      = '0;
      end else begin
        tail      = {32'b0, w} & ((64'd1 << (8 * take)) - 64'd1);
        len_model = len_model + {61'b0, take};
      end
      h = mix_round(h, tail);
      h = mix_round(h, len_model);
      h = h ^ (h >> FIN_SH_A);
      h = h * HASH_MUL;
      h = h ^ (h >> FIN_SH_B);
      digest    = h;
      acc_model = seed_model;
      len_model = '0;
    end
  endtask

  // offer one word after a random gap, wait for it to be taken, then predict
  task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic fin,
                           input logic known, input logic [63:0] known_hash);
    int unsigned gap;
    logic        done;
    logic [63:0] digest;
    gap = brisk ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_word  <= w;
    byte_count <= n;
    last       <= fin;
    do @(posedge clk); while (in_stall);
    hash_step(w, n, fin, done, digest);
    if (done) begin
      pending_hashes.push_back(known ? known_hash : digest);
      msgs_sent++;
    end
    words_sent++;
  endtask

  // stop offering and wait until every hash has come back
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk);
  endtask

  // seed write, only with the block idle
  task automatic write_seed(input logic [63:0] v);
    drain();
    repeat (16) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seed_model = v;
    if (len_model == 64'd0) acc_model = v;
    seeds_written++;
  endtask

  // random message: mostly short, now and then long, inner counts mostly full
  task automatic send_message(output int unsigned nw);
    int unsigned pick;
    logic [31:0] w;
    logic [2:0]  n;
    pick = $urandom_range(0, 99);
    if (pick < 80)      nw = $urandom_range(1, 6);
    else if (pick < 95) nw = $urandom_range(7, 20);
    else                nw = $urandom_range(21, 48);
    for (int unsigned i = 0; i < nw; i++) begin
      pick = $urandom_range(0, 15);
      w    = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      if (i + 1 < nw) begin
        n = ($urandom_range(0, 99) < 85) ? FULL_WORD : 3'($urandom_range(0, 7));
        send_word(w, n, 1'b0, 1'b0, '0);
      end else begin
        send_word(w, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
      end
    end
  endtask

  // receiver: random hold-off per hash, one long hold on request
  initial begin : receiver
    int unsigned gap;
    out_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        gap = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        gap = brisk ? 0 : $urandom_range(0, 17);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // compare every taken hash with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_hashes.size() == 0) begin
        $error("hash_value: no hash expected, got %h", hash_value);
        mismatches++;
      end else begin
        logic [63:0] want;
        want = pending_hashes.pop_front();
        if (hash_value !== want) begin
          $error("hash_value: expected %h, actual %h", want, hash_value);
          mismatches++;
        end
        hashes_checked++;
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [63:0] phase_seeds [5];
    int unsigned phase_words;
    int unsigned nw;
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    data_word  <= '0;
    byte_count <= '0;
    last       <= 1'b0;
    seed_model = '0;
    acc_model  = '0;
    len_model  = '0;
    mismatches = 0;
    words_sent = 0;
    msgs_sent  = 0;
    hashes_checked = 0;
    seeds_written  = 0;
    brisk         = 1'b0;
    long_hold_req = 1'b0;
    phase_seeds[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    phase_seeds[1] = 64'h8000_0000_0000_0000;
    phase_seeds[2] = {$urandom, $urandom};
    phase_seeds[3] = 64'h0;
    phase_seeds[4] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table under the reset seed
    foreach (dir_rows[i])
      send_word(dir_rows[i].data, dir_rows[i].nbytes, dir_rows[i].fin,
                dir_rows[i].known, dir_rows[i].hash);

    // random messages, one seed per phase
    for (int p = 0; p < 5; p++) begin
      write_seed(phase_seeds[p]);
      brisk = (p == 1);
      if (p == 2) long_hold_req = 1'b1;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        send_message(nw);
        phase_words += nw;
        // sender pause mid-phase until the output side is empty
        if (p == 3 && phase_words >= PHASE_WORDS / 2 && phase_words - nw < PHASE_WORDS / 2)
          drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d words in %0d messages, %0d hashes checked, %0d seed writes",
             words_sent, msgs_sent, hashes_checked, seeds_written);
    $display("directed extremes, tail lengths 0 to 7, long output hold and sender pause");
    if (mismatches == 0) begin
      $display("murmur_style_hash64_stream_test: PASS");
    end else begin
      $display("murmur_style_hash64_stream_test: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2_000_000;
    $display("murmur_style_hash64_stream_test: FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/mshash_pkg.sv
design/mshash_ctrl.sv
design/mshash_dp.sv
design/murmur_style_hash64_stream.sv
verif/murmur_style_hash64_stream_test.sv
